[sv/assert_macros.svh]
// Assertion macros used by the top level of the gate drive controller.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property with active-low reset masking.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[sv/lrgd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and the microcode program of the gate drive controller.
// No dependencies.
package lrgd_pkg;

    // Ramp modes
    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_STEADY = 2'd1;
    localparam logic [1:0] MODE_DOWN   = 2'd2;

    // Item opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_CELL  = 2'd1;
    localparam logic [1:0] OP_POWER = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_LEVEL_MIN  = 3'd0;
    localparam logic [2:0] REG_LEVEL_MAX  = 3'd1;
    localparam logic [2:0] REG_SHORT_THR  = 3'd2;
    localparam logic [2:0] REG_LONG_THR   = 3'd3;
    localparam logic [2:0] REG_CHARGE_OFF = 3'd4;
    localparam logic [2:0] REG_TICKS_STEP = 3'd5;

    // Reset values
    localparam logic [11:0] RST_LEVEL_MIN  = 12'd120;
    localparam logic [11:0] RST_LEVEL_MAX  = 12'd200;
    localparam logic [7:0]  RST_SHORT_THR  = 8'd240;
    localparam logic [7:0]  RST_LONG_THR   = 8'd180;
    localparam logic [7:0]  RST_CHARGE_OFF = 8'd6;
    localparam logic [7:0]  RST_TICKS_STEP = 8'd2;
    localparam logic [7:0]  CELL_FULL      = 8'd211;

    // Divider geometry: 12-bit level scaled twice by 256
    localparam int DVD_W  = 28;
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] DIV1_ITERS = 5'd20;
    localparam logic [CNT_W-1:0] DIV2_ITERS = 5'd28;

    // Datapath actions
    localparam logic [3:0] ACT_NOP    = 4'd0;
    localparam logic [3:0] ACT_TICK   = 4'd1;
    localparam logic [3:0] ACT_DIV1   = 4'd2;
    localparam logic [3:0] ACT_DIV2   = 4'd3;
    localparam logic [3:0] ACT_CHARGE = 4'd4;
    localparam logic [3:0] ACT_SAT    = 4'd5;
    localparam logic [3:0] ACT_EMIT   = 4'd6;
    localparam logic [3:0] ACT_CELL   = 4'd7;
    localparam logic [3:0] ACT_POWER  = 4'd8;

    // Jump conditions
    localparam logic [2:0] COND_NONE    = 3'd0;
    localparam logic [2:0] COND_ALWAYS  = 3'd1;
    localparam logic [2:0] COND_ZCELL   = 3'd2;
    localparam logic [2:0] COND_DIVBUSY = 3'd3;
    localparam logic [2:0] COND_OUTBLK  = 3'd4;

    // Program addresses
    localparam logic [3:0] PC_IDLE   = 4'd0;
    localparam logic [3:0] PC_TICK   = 4'd1;
    localparam logic [3:0] PC_DIV1   = 4'd2;
    localparam logic [3:0] PC_WAIT1  = 4'd3;
    localparam logic [3:0] PC_DIV2   = 4'd4;
    localparam logic [3:0] PC_WAIT2  = 4'd5;
    localparam logic [3:0] PC_CHARGE = 4'd6;
    localparam logic [3:0] PC_SAT    = 4'd7;
    localparam logic [3:0] PC_EMIT   = 4'd8;
    localparam logic [3:0] PC_CELL   = 4'd9;
    localparam logic [3:0] PC_POWER  = 4'd10;

    typedef struct packed {
        logic [3:0] act;
        logic [2:0] cond;
        logic [3:0] target;
        logic       ret;
    } t_uword;

    typedef struct packed {
        logic zero_cell;
        logic div_busy;
        logic out_blocked;
    } t_seq_status;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
        logic [DVD_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

    function automatic t_uword ucode_rom(input logic [3:0] pc);
        t_uword w;
        w = '{act: ACT_NOP, cond: COND_ALWAYS, target: PC_IDLE, ret: 1'b0};
        unique case (pc)
            PC_IDLE:   w = '{ACT_NOP,    COND_ALWAYS,  PC_IDLE,  1'b0};
            PC_TICK:   w = '{ACT_TICK,   COND_ZCELL,   PC_SAT,   1'b0};
            PC_DIV1:   w = '{ACT_DIV1,   COND_NONE,    PC_IDLE,  1'b0};
            PC_WAIT1:  w = '{ACT_NOP,    COND_DIVBUSY, PC_WAIT1, 1'b0};
            PC_DIV2:   w = '{ACT_DIV2,   COND_NONE,    PC_IDLE,  1'b0};
            PC_WAIT2:  w = '{ACT_NOP,    COND_DIVBUSY, PC_WAIT2, 1'b0};
            PC_CHARGE: w = '{ACT_CHARGE, COND_ALWAYS,  PC_EMIT,  1'b0};
            PC_SAT:    w = '{ACT_SAT,    COND_NONE,    PC_IDLE,  1'b0};
            PC_EMIT:   w = '{ACT_EMIT,   COND_OUTBLK,  PC_EMIT,  1'b1};
            PC_CELL:   w = '{ACT_CELL,   COND_ALWAYS,  PC_EMIT,  1'b0};
            PC_POWER:  w = '{ACT_POWER,  COND_ALWAYS,  PC_EMIT,  1'b0};
            default:   w = '{ACT_NOP,    COND_ALWAYS,  PC_IDLE,  1'b0};
        endcase
        return w;
    endfunction

    // Entry point of each opcode; the unused opcode goes straight to output.
    function automatic logic [3:0] entry_pc(input logic [1:0] op);
        logic [3:0] pc;
        pc = PC_EMIT;
        unique case (op)
            OP_TICK:  pc = PC_TICK;
            OP_CELL:  pc = PC_CELL;
            OP_POWER: pc = PC_POWER;
            default:  pc = PC_EMIT;
        endcase
        return pc;
    endfunction

endpackage

[sv/light_ramp_gate_drive_controller.sv]
`timescale 1ns / 1ps
// Top level of the LED gate drive controller: registers, datapath, output stage.
// Depends on lrgd_pkg, lrgd_seq, lrgd_div and assert_macros.svh.
//
// One item at a time runs through a small microcode program. A tick item
// steps the ramp and computes the gate charge with two serial divisions
// through one shared divider (20 then 28 quotient bits, one bit a cycle);
// a tick with a zero cell value skips the divisions. A new item is taken
// as soon as the sequencer returns to idle after its predecessor's result
// is loaded, even while that result still waits in the output register.
// A result that finds the output register full and blocked holds the last
// step. Configuration writes are always taken and are registered directly.
module light_ramp_gate_drive_controller
    import lrgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_sample,
    input  logic        i_memory_intact,
    input  logic        i_stored_valid,
    input  logic [11:0] i_stored_level,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_gate_charge,
    output logic        o_drive_update,
    output logic [1:0]  o_mode,
    output logic [11:0] o_level,
    output logic        o_save_request
);

`include "assert_macros.svh"

    // Configuration registers
    logic [11:0] r_lvl_min, r_lvl_max;
    logic [7:0]  r_short_thr, r_long_thr, r_charge_off, r_ticks_step;

    // Ramp state
    logic [11:0] r_level;
    logic [1:0]  r_mode;
    logic [7:0]  r_cell;
    logic [7:0]  r_phase;

    // Latched item fields
    logic [7:0]  r_smp;
    logic        r_intact, r_svalid;
    logic [11:0] r_slevel;

    // Result under construction
    logic [15:0] r_charge;
    logic        r_update, r_save;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_charge;
    logic        r_out_update, r_out_save;
    logic [1:0]  r_out_mode;
    logic [11:0] r_out_level;

    t_uword      ctrl;
    t_seq_status status;
    t_div_req    div_req;
    logic        seq_idle, div_busy;
    logic [DVD_W-1:0] quot;
    logic        in_xfer, cfg_xfer, out_blocked, emit;

    // Tick step
    logic [7:0]  ph_inc;
    logic        do_step;
    logic [11:0] tick_level;
    logic [1:0]  tick_mode;

    // Charge finish
    logic [DVD_W-2:0] half_q, off_ext, diff;
    logic [15:0] charge_val;

    // Power-on
    logic [11:0] clamp_level, pwr_level;
    logic [1:0]  pwr_mode;

    // Cell deadband
    logic [7:0]  band_hi, band_lo, cell_a, cell_val;

    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_blocked = r_out_valid && !i_out_ready;
    assign emit        = (ctrl.act == ACT_EMIT) && !out_blocked;

    assign status = '{zero_cell: r_cell == '0, div_busy: div_busy,
                      out_blocked: out_blocked};

    lrgd_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer),
        .i_op     (i_op),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_idle   (seq_idle)
    );

    // First pass divides level*256*256 (left-aligned), second the quotient*256.
    always_comb begin
        div_req.start    = (ctrl.act == ACT_DIV1) || (ctrl.act == ACT_DIV2);
        div_req.divisor  = r_cell;
        if (ctrl.act == ACT_DIV1) begin
            div_req.iters    = DIV1_ITERS;
            div_req.dividend = {r_level, 16'd0};
        end else begin
            div_req.iters    = DIV2_ITERS;
            div_req.dividend = {quot[19:0], 8'd0};
        end
    end

    lrgd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    always_comb begin
        // Advance the phase; step the level when the period is reached.
        ph_inc     = r_phase + 8'd1;
        do_step    = ph_inc >= r_ticks_step;
        tick_level = r_level;
        tick_mode  = r_mode;
        if (do_step) begin
            if (r_mode == MODE_UP) begin
                if (r_level != 12'hFFF) begin
                    tick_level = r_level + 12'd1;
                end
                if (tick_level >= r_lvl_max) begin
                    tick_mode = MODE_STEADY;
                end
            end else if (r_mode == MODE_DOWN) begin
                if (r_level != 12'd0) begin
                    tick_level = r_level - 12'd1;
                end
                if (tick_level <= r_lvl_min) begin
                    tick_mode = MODE_STEADY;
                end
            end
        end

        // Halve, drop the offset, saturate to 16 bits.
        half_q  = quot[DVD_W-1:1];
        off_ext = {{(DVD_W-9){1'b0}}, r_charge_off};
        diff    = half_q - off_ext;
        if (half_q <= off_ext) begin
            charge_val = 16'd0;
        end else if (diff[DVD_W-2:16] != '0) begin
            charge_val = 16'hFFFF;
        end else begin
            charge_val = diff[15:0];
        end

        // Power-on: clamp, then classify the press.
        clamp_level = (r_level >= r_lvl_max) ? r_lvl_max : r_level;
        if (r_intact && (r_smp > r_short_thr)) begin
            pwr_level = clamp_level;
            pwr_mode  = (r_mode == MODE_STEADY) ? MODE_UP : MODE_STEADY;
        end else if (r_smp > r_long_thr) begin
            pwr_level = r_svalid ? r_slevel : clamp_level;
            pwr_mode  = MODE_DOWN;
        end else begin
            pwr_level = r_lvl_min;
            pwr_mode  = MODE_UP;
        end

        // Deadband of one count either side, band edges wrap.
        band_hi  = r_smp + 8'd1;
        band_lo  = r_smp - 8'd1;
        cell_a   = (band_hi < r_cell) ? band_hi : r_cell;
        cell_val = (band_lo > cell_a) ? band_lo : cell_a;
    end

    // Control and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_min    <= RST_LEVEL_MIN;
            r_lvl_max    <= RST_LEVEL_MAX;
            r_short_thr  <= RST_SHORT_THR;
            r_long_thr   <= RST_LONG_THR;
            r_charge_off <= RST_CHARGE_OFF;
            r_ticks_step <= RST_TICKS_STEP;
            r_level      <= RST_LEVEL_MIN;
            r_mode       <= MODE_UP;
            r_cell       <= CELL_FULL;
            r_phase      <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                case (i_cfg_index)
                    REG_LEVEL_MIN:  r_lvl_min    <= i_cfg_data;
                    REG_LEVEL_MAX:  r_lvl_max    <= i_cfg_data;
                    REG_SHORT_THR:  r_short_thr  <= i_cfg_data[7:0];
                    REG_LONG_THR:   r_long_thr   <= i_cfg_data[7:0];
                    REG_CHARGE_OFF: r_charge_off <= i_cfg_data[7:0];
                    REG_TICKS_STEP: r_ticks_step <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (ctrl.act)
                ACT_TICK: begin
                    r_phase <= do_step ? 8'd0 : ph_inc;
                    r_level <= tick_level;
                    r_mode  <= tick_mode;
                end
                ACT_CELL: begin
                    r_cell <= cell_val;
                end
                ACT_POWER: begin
                    r_level <= pwr_level;
                    r_mode  <= pwr_mode;
                end
                default: ;
            endcase
            // Hold a waiting result; drop it once transferred.
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_smp    <= i_sample;
            r_intact <= i_memory_intact;
            r_svalid <= i_stored_valid;
            r_slevel <= i_stored_level;
            r_charge <= 16'd0;
            r_update <= 1'b0;
            r_save   <= 1'b0;
        end else begin
            case (ctrl.act)
                ACT_TICK: begin
                    r_update <= 1'b1;
                    r_save   <= tick_mode != r_mode;
                end
                ACT_CHARGE: r_charge <= charge_val;
                ACT_SAT:    r_charge <= 16'hFFFF;
                ACT_POWER:  r_save   <= 1'b1;
                default: ;
            endcase
        end
        if (emit) begin
            r_out_charge <= r_charge;
            r_out_update <= r_update;
            r_out_save   <= r_save;
            r_out_mode   <= r_mode;
            r_out_level  <= r_level;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = seq_idle;
    assign o_out_valid    = r_out_valid;
    assign o_gate_charge  = r_out_charge;
    assign o_drive_update = r_out_update;
    assign o_mode         = r_out_mode;
    assign o_level        = r_out_level;
    assign o_save_request = r_out_save;

    // The shared divider is never restarted mid-division.
    `ASSERT_CLK(a_div_start_idle, i_clk, i_rst_n, div_req.start |-> !div_busy)
    // A transfer in sends the sequencer off idle in the next cycle.
    `ASSERT_CLK(a_busy_after_xfer, i_clk, i_rst_n, in_xfer |=> !o_in_ready)
    // Only tick results carry a gate charge.
    `ASSERT_NEVER(a_charge_only_tick, i_clk, i_rst_n,
                  o_out_valid && !o_drive_update && (o_gate_charge != 16'd0))

endmodule

[sv/lrgd_div.sv]
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle, MSB-first dividend.
// Depends on lrgd_pkg.
module lrgd_div
    import lrgd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quot
);

    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DVD_W-1:0] r_dvd,  n_dvd;
    logic [DVD_W-1:0] r_quot, n_quot;
    logic [7:0]       r_rem,  n_rem;
    logic [7:0]       r_dsr,  n_dsr;
    logic [8:0]       trial;
    logic             fits;

    always_comb begin
        trial  = {r_rem, r_dvd[DVD_W-1]};
        fits   = trial >= {1'b0, r_dsr};
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_cnt  = i_req.iters;
            n_dvd  = i_req.dividend;
            n_quot = '0;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_dvd  = {r_dvd[DVD_W-2:0], 1'b0};
            n_quot = {r_quot[DVD_W-2:0], fits};
            n_rem  = fits ? 8'(trial - {1'b0, r_dsr}) : trial[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;

endmodule

[sv/lrgd_seq.sv]
`timescale 1ns / 1ps
// Microcode sequencer: step counter, program table and conditional jumps.
// Depends on lrgd_pkg.
module lrgd_seq
    import lrgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_op,
    input  t_seq_status i_status,
    output t_uword      o_ctrl,
    output logic        o_idle
);

    logic [3:0] r_pc, n_pc;
    t_uword     uw;
    logic       take;

    always_comb begin
        uw = ucode_rom(r_pc);
        unique case (uw.cond)
            COND_NONE:    take = 1'b0;
            COND_ALWAYS:  take = 1'b1;
            COND_ZCELL:   take = i_status.zero_cell;
            COND_DIVBUSY: take = i_status.div_busy;
            COND_OUTBLK:  take = i_status.out_blocked;
            default:      take = 1'b0;
        endcase
        if (i_start) begin
            n_pc = entry_pc(i_op);
        end else if (take) begin
            n_pc = uw.target;
        end else if (uw.ret) begin
            n_pc = PC_IDLE;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = uw;
    assign o_idle = r_pc == PC_IDLE;

endmodule
